// ===== design/fcs_pkg.sv =====
// Package for the frequency channel summer: register widths, reset values,
// register indexes and the structs passed between the block's modules.
// No dependencies.
`default_nettype none

package fcs_pkg;

    localparam int CFG_FACTOR_W = 9;
    localparam int CFG_WIDTH_W  = 4;
    localparam int CFG_CHAN_W   = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_ADDR_W   = 2;

    localparam int IN_DATA_W    = 32;
    localparam int SUM_W        = 40;

    localparam int DEF_MAX_GROUP_WIDTH = 8;
    localparam int DEF_SAMPLE_BITS     = 32;
    localparam int DEF_MAX_FACTOR      = 256;
    localparam int DEF_MAX_CHANNELS    = 4096;

    localparam logic [CFG_FACTOR_W-1:0] RST_GROUP_FACTOR   = 9'd1;
    localparam logic [CFG_WIDTH_W-1:0]  RST_GROUP_WIDTH    = 4'd1;
    localparam logic [CFG_CHAN_W-1:0]   RST_INPUT_CHANNELS = 13'd1024;

    // Remainder unit: a load step, then one dividend bit a cycle
    localparam int DIV_STEPS = CFG_CHAN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 2);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GROUP_FACTOR   = 2'd0,
        REG_GROUP_WIDTH    = 2'd1,
        REG_INPUT_CHANNELS = 2'd2
    } t_reg_idx;

    // Saturated register values and the number of channels that form whole groups
    typedef struct packed {
        logic [CFG_FACTOR_W-1:0] factor;
        logic [CFG_WIDTH_W-1:0]  width;
        logic [CFG_CHAN_W-1:0]   nchan;
        logic [CFG_CHAN_W-1:0]   used;
    } t_cfg_lim;

    typedef struct packed {
        logic first;
        logic emit;
        logic last;
    } t_item_flags;

endpackage

`default_nettype wire

// ===== design/frequency_channel_summer_unit.sv =====
// Frequency channel summer: sums group_factor adjacent channels per position.
// A result leaves on m_axis via the fcs_acc stage-one and output registers.
// Throughput: one item per cycle unless the skid stage holds an item or the
// remainder unit is busy; the read-add-write loop on the sum memory runs in
// two stages with forwarding. After reset and each configuration write the
// remainder unit loads, then steps per channel-count bit; s_axis_tready is low.
`default_nettype none

module frequency_channel_summer_unit #(
    parameter int MAX_GROUP_WIDTH = fcs_pkg::DEF_MAX_GROUP_WIDTH,
    parameter int SAMPLE_BITS     = fcs_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_FACTOR      = fcs_pkg::DEF_MAX_FACTOR,
    parameter int MAX_CHANNELS    = fcs_pkg::DEF_MAX_CHANNELS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fcs_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [fcs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [fcs_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] sample
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [fcs_pkg::SUM_W-1:0]           m_axis_tdata,  // [39:0] channel_sum
    output logic                                m_axis_tlast   // last_of_spectrum
);
    import fcs_pkg::*;

    localparam int PW = (MAX_GROUP_WIDTH > 1) ? $clog2(MAX_GROUP_WIDTH) : 1;

    t_cfg_lim         lim;
    logic             busy;
    logic             en;
    logic             acc;
    logic [PW-1:0]    pos;
    t_item_flags      flags;
    logic             res_valid;
    logic [SUM_W-1:0] res_sum;
    logic             res_last;

    logic             r_ov;
    logic [SUM_W-1:0] r_osum;
    logic             r_olast;
    logic             r_kv;
    logic [SUM_W-1:0] r_ksum;
    logic             r_klast;
    logic             take;

    fcs_cfg #(
        .MAX_GROUP_WIDTH (MAX_GROUP_WIDTH),
        .MAX_FACTOR      (MAX_FACTOR),
        .MAX_CHANNELS    (MAX_CHANNELS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_lim      (lim),
        .o_busy     (busy)
    );

    fcs_seq #(
        .MAX_GROUP_WIDTH (MAX_GROUP_WIDTH),
        .MAX_FACTOR      (MAX_FACTOR),
        .MAX_CHANNELS    (MAX_CHANNELS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_lim   (lim),
        .o_pos   (pos),
        .o_flags (flags)
    );

    fcs_acc #(
        .MAX_GROUP_WIDTH (MAX_GROUP_WIDTH),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_acc    (acc),
        .i_pos    (pos),
        .i_flags  (flags),
        .i_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_valid  (res_valid),
        .o_sum    (res_sum),
        .o_last   (res_last)
    );

    // Advance the pipeline unless the skid stage is full or the remainder unit busy
    assign en            = !r_kv && !busy;
    assign s_axis_tready = en;
    assign acc           = s_axis_tvalid && en;
    assign take          = r_ov && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_kv <= 1'b0;
        end else if (r_kv) begin
            if (take) begin
                r_kv <= 1'b0;
            end
        end else if (en && res_valid) begin
            if (r_ov && !take)
                r_kv <= 1'b1;
            else
                r_ov <= 1'b1;
        end else if (take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_kv) begin
            if (take) begin
                r_osum  <= r_ksum;
                r_olast <= r_klast;
            end
        end else if (en && res_valid) begin
            if (r_ov && !take) begin
                r_ksum  <= res_sum;
                r_klast <= res_last;
            end else begin
                r_osum  <= res_sum;
                r_olast <= res_last;
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_osum;
    assign m_axis_tlast  = r_olast;

endmodule

`default_nettype wire

// ===== design/fcs_cfg.sv =====
// Configuration registers of the frequency channel summer with saturation,
// and a bit-serial remainder unit that finds the channels forming whole groups.
// Depends on fcs_pkg.
`default_nettype none

module fcs_cfg #(
    parameter int MAX_GROUP_WIDTH = fcs_pkg::DEF_MAX_GROUP_WIDTH,
    parameter int MAX_FACTOR      = fcs_pkg::DEF_MAX_FACTOR,
    parameter int MAX_CHANNELS    = fcs_pkg::DEF_MAX_CHANNELS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fcs_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [fcs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output fcs_pkg::t_cfg_lim                  o_lim,
    output logic                               o_busy
);
    import fcs_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LOAD = DIV_CNT_W'(DIV_STEPS + 1);

    logic [CFG_FACTOR_W-1:0] r_factor;
    logic [CFG_WIDTH_W-1:0]  r_width;
    logic [CFG_CHAN_W-1:0]   r_nchan;

    logic [CFG_FACTOR_W-1:0] lim_factor;
    logic [CFG_WIDTH_W-1:0]  lim_width;
    logic [CFG_CHAN_W-1:0]   lim_nchan;

    logic [DIV_CNT_W-1:0]    r_cnt;
    logic [CFG_CHAN_W-1:0]   r_dvd;
    logic [CFG_FACTOR_W-1:0] r_rem;
    logic [CFG_FACTOR_W-1:0] n_rem;
    logic [CFG_FACTOR_W:0]   trial;
    logic [CFG_CHAN_W-1:0]   r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= RST_GROUP_FACTOR;
            r_width  <= RST_GROUP_WIDTH;
            r_nchan  <= RST_INPUT_CHANNELS;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_GROUP_FACTOR:   r_factor <= i_cfg_data[CFG_FACTOR_W-1:0];
                REG_GROUP_WIDTH:    r_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                REG_INPUT_CHANNELS: r_nchan  <= i_cfg_data[CFG_CHAN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        if (r_factor == '0)
            lim_factor = CFG_FACTOR_W'(1);
        else if (r_factor > MAX_FACTOR)
            lim_factor = CFG_FACTOR_W'(MAX_FACTOR);
        else
            lim_factor = r_factor;

        if (r_width == '0)
            lim_width = CFG_WIDTH_W'(1);
        else if (r_width > MAX_GROUP_WIDTH)
            lim_width = CFG_WIDTH_W'(MAX_GROUP_WIDTH);
        else
            lim_width = r_width;

        if (r_nchan == '0)
            lim_nchan = CFG_CHAN_W'(1);
        else if (r_nchan > MAX_CHANNELS)
            lim_nchan = CFG_CHAN_W'(MAX_CHANNELS);
        else
            lim_nchan = r_nchan;
    end

    // Restoring remainder step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[CFG_CHAN_W-1]};
        if (trial >= {1'b0, lim_factor})
            n_rem = CFG_FACTOR_W'(trial - {1'b0, lim_factor});
        else
            n_rem = CFG_FACTOR_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_LOAD;
        end else if (i_cfg_we) begin
            r_cnt <= CNT_LOAD;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cnt == CNT_LOAD) begin
            r_dvd <= lim_nchan;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[CFG_CHAN_W-2:0], 1'b0};
            r_rem <= n_rem;
            if (r_cnt == DIV_CNT_W'(1))
                r_used <= lim_nchan - {{(CFG_CHAN_W-CFG_FACTOR_W){1'b0}}, n_rem};
        end
    end

    assign o_lim.factor = lim_factor;
    assign o_lim.width  = lim_width;
    assign o_lim.nchan  = lim_nchan;
    assign o_lim.used   = r_used;
    assign o_busy       = (r_cnt != '0);

endmodule

`default_nettype wire

// ===== design/fcs_seq.sv =====
// Position, channel-in-group and channel counters of the frequency channel
// summer; gives the memory address and the first/emit/last flags of each item.
// Depends on fcs_pkg.
`default_nettype none

module fcs_seq #(
    parameter int MAX_GROUP_WIDTH = fcs_pkg::DEF_MAX_GROUP_WIDTH,
    parameter int MAX_FACTOR      = fcs_pkg::DEF_MAX_FACTOR,
    parameter int MAX_CHANNELS    = fcs_pkg::DEF_MAX_CHANNELS,
    localparam int PW = (MAX_GROUP_WIDTH > 1) ? $clog2(MAX_GROUP_WIDTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_acc,
    input  wire fcs_pkg::t_cfg_lim i_lim,
    output logic [PW-1:0]          o_pos,
    output fcs_pkg::t_item_flags   o_flags
);
    import fcs_pkg::*;

    localparam int GW = $clog2(MAX_FACTOR);
    localparam int CW = $clog2(MAX_CHANNELS);

    logic [PW-1:0] r_pos, n_pos, pos0, pos;
    logic [GW-1:0] r_cig, n_cig, cig0, cig;
    logic [CW-1:0] r_ch,  n_ch,  ch;
    logic          wrap;
    logic [PW:0]   pos_inc;
    logic [GW:0]   cig_inc;
    logic [CW:0]   ch_inc;
    logic [CFG_FACTOR_W-1:0] factor_m1;
    logic [CFG_WIDTH_W-1:0]  width_m1;
    logic [CFG_CHAN_W-1:0]   used_m1;

    always_comb begin
        // Restart counters that lie beyond the current register values
        wrap = (r_ch >= i_lim.nchan);
        ch   = wrap ? '0 : r_ch;
        cig0 = wrap ? '0 : r_cig;
        pos0 = wrap ? '0 : r_pos;
        pos  = (pos0 >= i_lim.width)  ? '0 : pos0;
        cig  = (cig0 >= i_lim.factor) ? '0 : cig0;

        factor_m1 = i_lim.factor - CFG_FACTOR_W'(1);
        width_m1  = i_lim.width  - CFG_WIDTH_W'(1);
        used_m1   = i_lim.used   - CFG_CHAN_W'(1);

        o_pos         = pos;
        o_flags.first = (cig == '0);
        o_flags.emit  = (cig == factor_m1) && (ch < i_lim.used);
        o_flags.last  = (ch == used_m1) && (pos == width_m1);

        pos_inc = {1'b0, pos} + (PW+1)'(1);
        cig_inc = {1'b0, cig} + (GW+1)'(1);
        ch_inc  = {1'b0, ch}  + (CW+1)'(1);
        n_pos   = PW'(pos_inc);
        n_cig   = cig;
        n_ch    = ch;
        if (pos_inc >= i_lim.width) begin
            n_pos = '0;
            n_cig = (cig_inc >= i_lim.factor) ? '0 : GW'(cig_inc);
            if (ch_inc >= i_lim.nchan) begin
                n_ch  = '0;
                n_cig = '0;
            end else begin
                n_ch = CW'(ch_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_cig <= '0;
            r_ch  <= '0;
        end else if (i_acc) begin
            r_pos <= n_pos;
            r_cig <= n_cig;
            r_ch  <= n_ch;
        end
    end

endmodule

`default_nettype wire

// ===== design/fcs_acc.sv =====
// Partial-sum memory of the frequency channel summer: registered read,
// add in the second stage, write-back with forwarding of the same entry.
// Depends on fcs_pkg.
`default_nettype none

module fcs_acc #(
    parameter int MAX_GROUP_WIDTH = fcs_pkg::DEF_MAX_GROUP_WIDTH,
    parameter int SAMPLE_BITS     = fcs_pkg::DEF_SAMPLE_BITS,
    localparam int PW = (MAX_GROUP_WIDTH > 1) ? $clog2(MAX_GROUP_WIDTH) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_acc,
    input  wire logic [PW-1:0]             i_pos,
    input  wire fcs_pkg::t_item_flags      i_flags,
    input  wire logic [SAMPLE_BITS-1:0]    i_sample,
    output logic                           o_valid,
    output logic [fcs_pkg::SUM_W-1:0]      o_sum,
    output logic                           o_last
);
    import fcs_pkg::*;

    logic [SUM_W-1:0]           r_mem [MAX_GROUP_WIDTH];
    logic [MAX_GROUP_WIDTH-1:0] r_vld;

    logic                   r_v1;
    logic [PW-1:0]          r_pos1;
    t_item_flags            r_flags1;
    logic [SAMPLE_BITS-1:0] r_smp1;
    logic [SUM_W-1:0]       r_rd;
    logic                   r_rdv;
    logic                   r_hit;
    logic [SUM_W-1:0]       r_fwd;

    logic [SUM_W-1:0]       ext;
    logic [SUM_W-1:0]       old;
    logic [SUM_W-1:0]       sum1;

    always_comb begin
        ext = {{(SUM_W-SAMPLE_BITS){r_smp1[SAMPLE_BITS-1]}}, r_smp1};
        // Take the value written at the read edge; an entry never written reads zero
        if (r_hit)
            old = r_fwd;
        else if (r_rdv)
            old = r_rd;
        else
            old = '0;
        sum1 = r_flags1.first ? ext : old + ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_vld <= '0;
        end else if (i_en) begin
            r_v1 <= i_acc;
            if (r_v1)
                r_vld[r_pos1] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_v1)
            r_mem[r_pos1] <= sum1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_acc) begin
            r_pos1   <= i_pos;
            r_flags1 <= i_flags;
            r_smp1   <= i_sample;
            r_rd     <= r_mem[i_pos];
            r_rdv    <= r_vld[i_pos];
            r_hit    <= r_v1 && (r_pos1 == i_pos);
            r_fwd    <= sum1;
        end
    end

    assign o_valid = r_v1 && r_flags1.emit;
    assign o_sum   = sum1;
    assign o_last  = r_flags1.last;

endmodule

`default_nettype wire
